// ===== hdl/rvcd_pkg.sv =====
// Shared types and constants for the run-length voxel column decoder.
`timescale 1ns / 1ps

package rvcd_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned OffW     = 16;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned YW       = 17;
  localparam int unsigned RunW     = 6;
  localparam int unsigned SkipW    = 10;
  localparam int unsigned VoxW     = 17;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgIdxW  = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PALETTE_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_X       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_Y       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_Z       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_X     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_Y     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_Z     = 3'd6;

  typedef struct packed {
    logic              palette_mode;
    logic [SizeW-1:0]  size_x;
    logic [SizeW-1:0]  size_y;
    logic [SizeW-1:0]  size_z;
    logic [OffW-1:0]   offset_x;
    logic [OffW-1:0]   offset_y;
    logic [OffW-1:0]   offset_z;
  } cfg_t;

  // One colour word that lands inside the volume, ready for the back end
  typedef struct packed {
    logic [YW-1:0]     height;
    logic [CoordW-1:0] column_x;
    logic [CoordW-1:0] slice_z;
    logic [WordW-1:0]  word;
    logic              overflow;
  } voxel_job_t;

endpackage

// ===== hdl/rle_voxel_column_decoder.sv =====
// Top level of the run-length voxel column decoder: config registers and wiring.
`timescale 1ns / 1ps
// A colour word's voxel passes a queue entry, then the output register, to m_axis.
// Throughput: one stream word per cycle, set by the slab store's single prefetched
// read port and the queue that lets the parser run while the builder waits, until full.
// Counts, slab words and colour words with no voxel give no output beat.
// Reset (rst_ni, async, active low) clears parser state and queue and loads the
// register defaults; the slab store is not cleared, as it is written before read.

module rle_voxel_column_decoder import rvcd_pkg::*; #(
  parameter int unsigned MAX_RUNS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WordW-1:0]    s_axis_tdata,  // [15:0] word
  // voxel stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [16:0] voxel_x, [33:17] voxel_y, [50:34] voxel_z, [58:51] index_byte,
  // [66:59] green_byte, [74:67] blue_byte, [75] slab_overflow, [79:76] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [WordW-1:0]    cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  logic       cfg_we;

  logic       job_valid, job_ready;
  voxel_job_t job;
  logic       qjob_valid, qjob_ready;
  voxel_job_t qjob;

  // registers are always writable; the user must change them only when idle, unenforced
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_PALETTE_MODE: cfg_d.palette_mode = cfg_data_i[0];
        CFG_SIZE_X:       cfg_d.size_x       = cfg_data_i[SizeW-1:0];
        CFG_SIZE_Y:       cfg_d.size_y       = cfg_data_i[SizeW-1:0];
        CFG_SIZE_Z:       cfg_d.size_z       = cfg_data_i[SizeW-1:0];
        CFG_OFFSET_X:     cfg_d.offset_x     = cfg_data_i;
        CFG_OFFSET_Y:     cfg_d.offset_y     = cfg_data_i;
        CFG_OFFSET_Z:     cfg_d.offset_z     = cfg_data_i;
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.palette_mode <= 1'b1;
      cfg_q.size_x       <= SizeW'(256);
      cfg_q.size_y       <= SizeW'(256);
      cfg_q.size_z       <= SizeW'(256);
      cfg_q.offset_x     <= '0;
      cfg_q.offset_y     <= '0;
      cfg_q.offset_z     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: walks the column layout, fills the slab store, matches colours to heights
  rvcd_front #(
    .MAX_RUNS (MAX_RUNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .word_valid_i (s_axis_tvalid),
    .word_ready_o (s_axis_tready),
    .word_i       (s_axis_tdata),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  // short queue so the parser and the builder stall independently
  rvcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (qjob_valid),
    .pop_ready_i  (qjob_ready),
    .pop_data_o   (qjob)
  );

  // back: coordinate offsets, colour index and bytes, output register
  rvcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_valid_i   (qjob_valid),
    .job_ready_o   (qjob_ready),
    .job_i         (qjob),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== hdl/rvcd_queue.sv =====
// Two-entry queue carrying voxel jobs from the parser to the voxel builder.
`timescale 1ns / 1ps

module rvcd_queue import rvcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  voxel_job_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output voxel_job_t pop_data_o
);

  voxel_job_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/rvcd_front.sv =====
// Stream parser: column phases, slab store, colour-to-height matching.
`timescale 1ns / 1ps

module rvcd_front import rvcd_pkg::*; #(
  parameter int unsigned MAX_RUNS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             word_valid_i,
  output logic             word_ready_o,
  input  logic [WordW-1:0] word_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output voxel_job_t       job_o
);

  localparam int unsigned CW = $clog2(MAX_RUNS + 1);
  localparam int unsigned AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam logic [CW-1:0] MaxRunsC = CW'(MAX_RUNS);
  localparam int unsigned EW = HeightW + RunW;

  localparam logic [1:0] PH_SLAB_COUNT  = 2'd0;
  localparam logic [1:0] PH_COLOR_COUNT = 2'd1;
  localparam logic [1:0] PH_SLABS       = 2'd2;
  localparam logic [1:0] PH_COLORS      = 2'd3;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] r;
    r = s;
    if (s == '0) begin
      r = SizeW'(1);
    end else if (s > SizeW'(4096)) begin
      r = SizeW'(4096);
    end
    return r;
  endfunction

  logic [1:0]         phase_q, phase_d;
  logic [WordW-1:0]   slabs_left_q, slabs_left_d;
  logic [WordW-1:0]   colors_left_q, colors_left_d;
  logic [CW-1:0]      runs_stored_q, runs_stored_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic [RunW-1:0]    pos_q, pos_d;
  logic [HeightW-1:0] height_q, height_d;
  logic [CoordW-1:0]  col_x_q, col_x_d;
  logic [CoordW-1:0]  slice_z_q, slice_z_d;
  logic               ovf_q, ovf_d;

  logic [EW-1:0]      store_mem [MAX_RUNS];
  logic [EW-1:0]      rd_entry_q;
  logic [EW-1:0]      wr_entry;
  logic               store_we;

  logic               accept;
  logic [SkipW-1:0]   skip;
  logic [RunW-1:0]    run;
  logic [HeightW:0]   h_skip_sum, h_run_sum;
  logic [HeightW-1:0] h_skip, h_run;
  logic               has_room;
  logic [HeightW-1:0] rd_start;
  logic [RunW-1:0]    rd_len;
  logic               hit;
  logic [YW-1:0]      y;
  logic               emit;
  logic [RunW:0]      pos_inc;
  logic [WordW-1:0]   slabs_dec, colors_dec;
  logic [CoordW:0]    col_inc, slice_inc;
  logic               end_col;

  assign word_ready_o = job_ready_i;
  assign accept       = word_valid_i && job_ready_i;

  assign skip       = word_i[SkipW-1:0];
  assign run        = word_i[WordW-1:SkipW];
  assign h_skip_sum = {1'b0, height_q} + (HeightW+1)'(skip);
  assign h_skip     = h_skip_sum[HeightW] ? '1 : h_skip_sum[HeightW-1:0];
  assign h_run_sum  = {1'b0, h_skip} + (HeightW+1)'(run);
  assign h_run      = h_run_sum[HeightW] ? '1 : h_run_sum[HeightW-1:0];
  assign has_room   = runs_stored_q < MaxRunsC;
  assign store_we   = accept && (phase_q == PH_SLABS) && (run != '0) && has_room;
  assign wr_entry   = {h_skip, run};

  assign rd_start = rd_entry_q[EW-1:RunW];
  assign rd_len   = rd_entry_q[RunW-1:0];
  assign hit      = (rd_idx_q < runs_stored_q) && (rd_idx_q < MaxRunsC);
  assign y        = {1'b0, rd_start} + YW'(pos_q);
  assign emit     = hit && (y < YW'(cfg_i.size_y));
  assign pos_inc  = {1'b0, pos_q} + (RunW+1)'(1);

  assign slabs_dec  = slabs_left_q - WordW'(1);
  assign colors_dec = colors_left_q - WordW'(1);
  assign col_inc    = {1'b0, col_x_q} + (CoordW+1)'(1);
  assign slice_inc  = {1'b0, slice_z_q} + (CoordW+1)'(1);

  assign job_valid_o    = accept && (phase_q == PH_COLORS) && emit;
  assign job_o.height   = y;
  assign job_o.column_x = col_x_q;
  assign job_o.slice_z  = slice_z_q;
  assign job_o.word     = word_i;
  assign job_o.overflow = ovf_q;

  always_comb begin
    phase_d       = phase_q;
    slabs_left_d  = slabs_left_q;
    colors_left_d = colors_left_q;
    runs_stored_d = runs_stored_q;
    rd_idx_d      = rd_idx_q;
    pos_d         = pos_q;
    height_d      = height_q;
    ovf_d         = ovf_q;
    end_col       = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_SLAB_COUNT: begin
          slabs_left_d  = word_i;
          runs_stored_d = '0;
          height_d      = '0;
          phase_d       = PH_COLOR_COUNT;
        end
        PH_COLOR_COUNT: begin
          colors_left_d = word_i;
          rd_idx_d      = '0;
          pos_d         = '0;
          if (slabs_left_q != '0) begin
            phase_d = PH_SLABS;
          end else if (word_i != '0) begin
            phase_d = PH_COLORS;
          end else begin
            end_col = 1'b1;
          end
        end
        PH_SLABS: begin
          height_d     = h_run;
          slabs_left_d = slabs_dec;
          if (run != '0) begin
            if (has_room) begin
              runs_stored_d = runs_stored_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (slabs_dec == '0) begin
            if (colors_left_q != '0) begin
              phase_d = PH_COLORS;
            end else begin
              end_col = 1'b1;
            end
          end
        end
        default: begin
          if (hit) begin
            if (pos_inc >= {1'b0, rd_len}) begin
              rd_idx_d = rd_idx_q + CW'(1);
              pos_d    = '0;
            end else begin
              pos_d = pos_inc[RunW-1:0];
            end
          end
          colors_left_d = colors_dec;
          if (colors_dec == '0) begin
            end_col = 1'b1;
          end
        end
      endcase
    end

    col_x_d   = col_x_q;
    slice_z_d = slice_z_q;
    if (end_col) begin
      phase_d = PH_SLAB_COUNT;
      if (col_inc >= clamp_size(cfg_i.size_x)) begin
        col_x_d = '0;
        if (slice_inc >= clamp_size(cfg_i.size_z)) begin
          slice_z_d = '0;
        end else begin
          slice_z_d = slice_inc[CoordW-1:0];
        end
      end else begin
        col_x_d = col_inc[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SLAB_COUNT;
      slabs_left_q  <= '0;
      colors_left_q <= '0;
      runs_stored_q <= '0;
      rd_idx_q      <= '0;
      pos_q         <= '0;
      height_q      <= '0;
      col_x_q       <= '0;
      slice_z_q     <= '0;
      ovf_q         <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      slabs_left_q  <= slabs_left_d;
      colors_left_q <= colors_left_d;
      runs_stored_q <= runs_stored_d;
      rd_idx_q      <= rd_idx_d;
      pos_q         <= pos_d;
      height_q      <= height_d;
      col_x_q       <= col_x_d;
      slice_z_q     <= slice_z_d;
      ovf_q         <= ovf_d;
    end
  end

  // Read port prefetches the entry at the next read index; a write to the
  // same entry in this cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[runs_stored_q[AW-1:0]] <= wr_entry;
    end
    if (store_we && (runs_stored_q[AW-1:0] == rd_idx_d[AW-1:0])) begin
      rd_entry_q <= wr_entry;
    end else begin
      rd_entry_q <= store_mem[rd_idx_d[AW-1:0]];
    end
  end

endmodule

// ===== hdl/rvcd_back.sv =====
// Voxel builder: coordinates and colour bytes, held in the output register.
`timescale 1ns / 1ps

module rvcd_back import rvcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  voxel_job_t          job_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic                load;

  logic [ByteW-1:0]    t;
  logic [2*ByteW-1:0]  prod;
  logic [2*ByteW:0]    q_sum;
  logic [ByteW:0]      q_est;
  logic [2*ByteW:0]    q_x255;
  logic [2*ByteW+1:0]  q_x255_top;
  logic [ByteW:0]      inten;
  logic [ByteW-1:0]    idx_pal, idx_grey, idx;
  logic [ByteW-1:0]    green, blue;
  logic [VoxW-1:0]     vx, vy, vz;

  assign load        = job_valid_i && (!out_valid_q || m_axis_tready);
  assign job_ready_o = !out_valid_q || m_axis_tready;
  assign out_valid_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // floor(t*t/255): reciprocal estimate, then one step of correction
  assign t          = job_i.word[ByteW-1:0];
  assign prod       = t * t;
  assign q_sum      = {1'b0, prod} + (2*ByteW+1)'(prod[2*ByteW-1:ByteW]) + (2*ByteW+1)'(1);
  assign q_est      = q_sum[2*ByteW:ByteW];
  assign q_x255     = {q_est, {ByteW{1'b0}}} - (2*ByteW+1)'(q_est);
  assign q_x255_top = {1'b0, q_x255} + (2*ByteW+2)'(255);

  always_comb begin
    inten = q_est;
    if (q_x255 > {1'b0, prod}) begin
      inten = q_est - (ByteW+1)'(1);
    end else if ((2*ByteW+2)'(prod) >= q_x255_top) begin
      inten = q_est + (ByteW+1)'(1);
    end
  end

  // the floor of 2 on the intensity vanishes once the low three bits drop
  assign idx_pal  = {inten[ByteW-1:3], 3'b000} + {6'b0, job_i.word[9:8]};
  assign idx_grey = ByteW'(1) + ((~t) & 8'hfc);
  assign idx      = cfg_i.palette_mode ? idx_pal : idx_grey;
  assign green    = {job_i.word[9:5], 3'b000};
  assign blue     = {job_i.word[14:10], 3'b000};

  assign vx = VoxW'(job_i.column_x) + {cfg_i.offset_x[OffW-1], cfg_i.offset_x};
  assign vz = VoxW'(job_i.slice_z) + {cfg_i.offset_z[OffW-1], cfg_i.offset_z};
  assign vy = VoxW'(cfg_i.size_y) - VoxW'(1) - job_i.height
            + {cfg_i.offset_y[OffW-1], cfg_i.offset_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= {4'b0000, job_i.overflow, blue, green, idx, vz, vy, vx};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/tb_rle_voxel_column_decoder.sv =====
// Self-checking testbench for the run-length voxel column decoder.
`timescale 1ns / 1ps

module tb_rle_voxel_column_decoder;
  import rvcd_pkg::*;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 16;

  // parser position within a column
  typedef enum logic [1:0] {
    EXPECT_SLAB_COUNT,
    EXPECT_COLOUR_COUNT,
    IN_SLABS,
    IN_COLOURS
  } parse_e;

  typedef struct packed {
    logic [VoxW-1:0]  x;
    logic [VoxW-1:0]  y;
    logic [VoxW-1:0]  z;
    logic [ByteW-1:0] idx_byte;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic             overflow;
  } voxel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WordW-1:0]    s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [WordW-1:0]    cfg_data_i = '0;

  rle_voxel_column_decoder #(.MAX_RUNS(StoreDepth)) DUT (.*);

  // predictor state
  cfg_t              shadow;
  parse_e            phase;
  logic [WordW-1:0]  slabs_left, colours_left, height;
  logic [WordW-1:0]  run_start [StoreDepth];
  logic [RunW-1:0]   run_len [StoreDepth];
  int unsigned       runs_stored, read_idx, pos_in_run, col_x, slice;
  logic              overflow;

  logic [WordW-1:0]  stream_words [$];
  voxel_t            pending_voxels [$];
  voxel_t            head;
  int unsigned       send_gap_pct = 0, recv_stall_pct = 0;
  int unsigned       mismatches = 0, words_in = 0, voxels_seen = 0;
  logic              hold_armed = 1'b0, hold_rx = 1'b0;

  initial forever #6 clk_i = ~clk_i;

  function automatic int unsigned clamp_extent(logic [SizeW-1:0] s);
    if (s == 0) return 1;
    if (s > 4096) return 4096;
    return 32'(s);
  endfunction

  function automatic logic [WordW-1:0] grow(logic [WordW-1:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 65535) ? 16'hFFFF : s[WordW-1:0];
  endfunction

  function automatic void next_column();
    phase = EXPECT_SLAB_COUNT;
    col_x++;
    if (col_x >= clamp_extent(shadow.size_x)) begin
      col_x = 0;
      slice++;
      if (slice >= clamp_extent(shadow.size_z)) slice = 0;
    end
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] val);
    case (idx)
      CFG_PALETTE_MODE: shadow.palette_mode = val[0];
      CFG_SIZE_X:       shadow.size_x = val[SizeW-1:0];
      CFG_SIZE_Y:       shadow.size_y = val[SizeW-1:0];
      CFG_SIZE_Z:       shadow.size_z = val[SizeW-1:0];
      CFG_OFFSET_X:     shadow.offset_x = val;
      CFG_OFFSET_Y:     shadow.offset_y = val;
      CFG_OFFSET_Z:     shadow.offset_z = val;
      default: ;
    endcase
  endfunction

  // Advance the column parser by one stream word; a colour word that lands
  // inside the volume adds one voxel to the expected queue.
  function automatic void decode_word(logic [WordW-1:0] w);
    logic [SkipW-1:0] skip;
    logic [RunW-1:0]  run;
    int               y, t, inten, idx, vx, vy, vz;
    voxel_t           v;
    case (phase)
      EXPECT_SLAB_COUNT: begin
        slabs_left = w;
        runs_stored = 0;
        height = '0;
        phase = EXPECT_COLOUR_COUNT;
      end
      EXPECT_COLOUR_COUNT: begin
        colours_left = w;
        read_idx = 0;
        pos_in_run = 0;
        if (slabs_left != 0) phase = IN_SLABS;
        else if (colours_left != 0) phase = IN_COLOURS;
        else next_column();
      end
      IN_SLABS: begin
        skip = w[SkipW-1:0];
        run = w[WordW-1:SkipW];
        height = grow(height, 32'(skip));
        if (run != 0) begin
          if (runs_stored < StoreDepth) begin
            run_start[runs_stored] = height;
            run_len[runs_stored] = run;
            runs_stored++;
          end else begin
            overflow = 1'b1;  // store full, run dropped
          end
        end
        height = grow(height, 32'(run));
        slabs_left--;
        if (slabs_left == 0) begin
          if (colours_left != 0) phase = IN_COLOURS;
          else next_column();
        end
      end
      default: begin
        if (read_idx < runs_stored) begin
          y = int'(run_start[read_idx]) + int'(pos_in_run);
          if (y < int'(shadow.size_y)) begin
            t = int'(w[7:0]);
            if (shadow.palette_mode) begin
              inten = (t * t) / 255;
              if (inten < 2) inten = 2;
              idx = int'(w[9:8]) + ((inten >> 3) << 3);
            end else begin
              idx = 1 + ((255 - t) & 'hfc);
            end
            vx = int'(col_x) + int'($signed(shadow.offset_x));
            vy = int'(shadow.size_y) - 1 - y + int'($signed(shadow.offset_y));
            vz = int'(slice) + int'($signed(shadow.offset_z));
            v.x = vx[VoxW-1:0];
            v.y = vy[VoxW-1:0];
            v.z = vz[VoxW-1:0];
            v.idx_byte = idx[ByteW-1:0];
            t = (int'(w) >> 5) << 3;
            v.green = t[ByteW-1:0];
            t = (int'(w) >> 10) << 3;
            v.blue = t[ByteW-1:0];
            v.overflow = overflow;
            pending_voxels.push_back(v);
          end
          pos_in_run++;
          if (pos_in_run >= int'(run_len[read_idx])) begin
            read_idx++;
            pos_in_run = 0;
          end
        end
        colours_left--;
        if (colours_left == 0) next_column();
      end
    endcase
  endfunction

  // One column: mostly well formed with random heights and colours, some with
  // colour counts that miss the runs, and some raw noise with small counts.
  task automatic add_column();
    logic [WordW-1:0] slab_words [$];
    logic [SkipW-1:0] skip;
    logic [RunW-1:0]  run;
    int unsigned      n_slabs, n_colours, covered, roll;
    covered = 0;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      n_slabs = $urandom_range(1, 5);
      repeat (n_slabs) begin
        skip = ($urandom_range(0, 7) == 0) ? SkipW'($urandom_range(0, 1023))
                                           : SkipW'($urandom_range(0, 12));
        if ($urandom_range(0, 9) == 0) run = '0;
        else if ($urandom_range(0, 19) == 0) run = RunW'($urandom_range(9, 63));
        else run = RunW'($urandom_range(1, 5));
        covered += 32'(run);
        slab_words.push_back({run, skip});
      end
      case ($urandom_range(0, 9))
        0: n_colours = covered + $urandom_range(1, 3);
        1: n_colours = $urandom_range(0, covered);
        default: n_colours = covered;
      endcase
    end else begin
      n_slabs = $urandom_range(0, 3);
      n_colours = $urandom_range(0, 4);
      repeat (n_slabs) slab_words.push_back(WordW'($urandom));
    end
    stream_words.push_back(WordW'(n_slabs));
    stream_words.push_back(WordW'(n_colours));
    foreach (slab_words[i]) stream_words.push_back(slab_words[i]);
    repeat (n_colours) stream_words.push_back(WordW'($urandom));
  endtask

  task automatic queue_columns(int unsigned n_words);
    while (stream_words.size() < n_words) add_column();
  endtask

  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_all(logic pm, logic [WordW-1:0] sx, sy, sz, ox, oy, oz);
    reg_write(CFG_PALETTE_MODE, {15'd0, pm});
    reg_write(CFG_SIZE_X, sx);
    reg_write(CFG_SIZE_Y, sy);
    reg_write(CFG_SIZE_Z, sz);
    reg_write(CFG_OFFSET_X, ox);
    reg_write(CFG_OFFSET_Y, oy);
    reg_write(CFG_OFFSET_Z, oz);
  endtask

  // wait for every word taken and every voxel seen, then let the pipe settle
  task automatic drain();
    while (stream_words.size() != 0 || s_axis_tvalid || pending_voxels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [VoxW-1:0] want, logic [VoxW-1:0] got);
    if (want !== got) begin
      $error("voxel field %s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // input side: a beat is taken when tvalid and tready meet at the edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_word(s_axis_tdata);
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stream_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= stream_words.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // voxel beats checked in order against the predicted queue
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      voxels_seen++;
      if (pending_voxels.size() == 0) begin
        $error("voxel beat with nothing expected: 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        head = pending_voxels.pop_front();
        check_field("voxel_x", head.x, m_axis_tdata[16:0]);
        check_field("voxel_y", head.y, m_axis_tdata[33:17]);
        check_field("voxel_z", head.z, m_axis_tdata[50:34]);
        check_field("index_byte", 17'(head.idx_byte), 17'(m_axis_tdata[58:51]));
        check_field("green_byte", 17'(head.green), 17'(m_axis_tdata[66:59]));
        check_field("blue_byte", 17'(head.blue), 17'(m_axis_tdata[74:67]));
        check_field("slab_overflow", 17'(head.overflow), 17'(m_axis_tdata[75]));
      end
    end
  end

  // long receiver hold-off so the decoder backs up into its input
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #4ms;
    $display("[rle_voxel_column_decoder] ERROR");
    $finish;
  end

  initial begin
    shadow = '{palette_mode: 1'b1, size_x: 13'd256, size_y: 13'd256, size_z: 13'd256,
               offset_x: '0, offset_y: '0, offset_z: '0};
    phase = EXPECT_SLAB_COUNT;
    slabs_left = '0;
    colours_left = '0;
    height = '0;
    runs_stored = 0;
    read_idx = 0;
    pos_in_run = 0;
    col_x = 0;
    slice = 0;
    overflow = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed columns at reset settings
    send_gap_pct = 0;
    recv_stall_pct = 0;
    // empty column
    stream_words.push_back(16'h0000); stream_words.push_back(16'h0000);
    // zero-length run folded into the skip, colours beyond the stored runs
    stream_words.push_back(16'd3); stream_words.push_back(16'd5);
    stream_words.push_back(16'h0800); stream_words.push_back(16'h0005);
    stream_words.push_back(16'h0403);
    stream_words.push_back(16'h0000); stream_words.push_back(16'hFFFF);
    stream_words.push_back(16'h00FF); stream_words.push_back(16'hFF00);
    stream_words.push_back(16'h8001);
    // colours with no slabs at all
    stream_words.push_back(16'd0); stream_words.push_back(16'd2);
    stream_words.push_back(16'h1234); stream_words.push_back(16'h5678);
    // slabs with no colours
    stream_words.push_back(16'd2); stream_words.push_back(16'd0);
    stream_words.push_back(16'h0C01); stream_words.push_back(16'h0402);
    // runs left over past the colour count, widest skip and run
    stream_words.push_back(16'd2); stream_words.push_back(16'd1);
    stream_words.push_back(16'h10FA); stream_words.push_back(16'hFFFF);
    stream_words.push_back(16'hAAAA);
    // store overflow at low heights: voxels carry the sticky flag
    stream_words.push_back(16'd66); stream_words.push_back(16'd3);
    repeat (66) stream_words.push_back(16'h0400);
    repeat (3) stream_words.push_back(WordW'($urandom));
    // height saturation: widest slabs until the height pins
    stream_words.push_back(16'd70); stream_words.push_back(16'd2);
    repeat (70) stream_words.push_back(16'hFFFF);
    repeat (2) stream_words.push_back(WordW'($urandom));
    drain();

    // grey index, tiny volume so x and z wrap, extreme offsets
    set_all(1'b0, 16'd3, 16'd4096, 16'd2, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_gap_pct = 10;
    recv_stall_pct = 88;
    queue_columns(420);
    drain();

    // size_x of zero and size_z beyond range, opposite offset extremes on x and y
    set_all(1'b1, 16'd0, 16'd100, 16'd8191, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_gap_pct = 88;
    recv_stall_pct = 10;
    queue_columns(420);
    drain();

    // zero height suppresses every voxel; widest row of columns
    set_all(1'b1, 16'd4096, 16'd0, 16'd1, 16'h0001, 16'h0002, 16'h0003);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    queue_columns(80);
    drain();

    // full rate both ends, with one long hold-off on the voxel side
    set_all(1'($urandom_range(0, 1)), 16'd5, 16'd64, 16'd3,
            WordW'($urandom), WordW'($urandom), WordW'($urandom));
    queue_columns(420);
    hold_armed = 1'b1;
    drain();

    $display("Covered %0d stream words and %0d voxel beats over five register settings,",
             words_in, voxels_seen);
    $display("including store overflow, height saturation, size clamping and volume wrap.");
    if (mismatches == 0) begin
      $display("[rle_voxel_column_decoder] OK");
    end else begin
      $display("[rle_voxel_column_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== rle_voxel_column_decoder.f =====
hdl/rvcd_pkg.sv
hdl/rvcd_queue.sv
hdl/rvcd_front.sv
hdl/rvcd_back.sv
hdl/rle_voxel_column_decoder.sv
tb/tb_rle_voxel_column_decoder.sv
